>>> design/swsr_pkg.sv
// ----------------------------------------------------------------------------
// Segment receiver package
// Sizes, operation and result codes, and the controller state type.
// ----------------------------------------------------------------------------
package swsr_pkg;

	localparam int RING_BYTES   = 524288;
	localparam int WINDOW_SLOTS = 128;
	localparam int MAX_PAYLOAD  = 1024;

	localparam int RING_AW  = $clog2(RING_BYTES);
	localparam int SLOT_W   = $clog2(WINDOW_SLOTS);
	localparam int OFF_W    = $clog2(MAX_PAYLOAD);
	localparam int PAY_AW   = SLOT_W + OFF_W;
	localparam int FILL_W   = RING_AW + 1;
	localparam int LEN_W    = OFF_W + 1;

	localparam logic [7:0] TIMEOUT_PROTO = 8'd42;
	localparam logic [6:0] READ_CAP      = 7'd64;
	localparam logic [FILL_W-1:0] ADV_LIMIT = FILL_W'(131072);

	typedef enum logic [1:0] {
		OP_DATA    = 2'd0,
		OP_TIMEOUT = 2'd1,
		OP_READ    = 2'd2,
		OP_OTHER   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOT_RD,
		ST_DRAIN_CHECK,
		ST_COPY,
		ST_ACK,
		ST_READ,
		ST_READ_OUT
	} state_t;

endpackage

>>> design/swsr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module swsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/sliding_window_segment_receiver.sv
// ----------------------------------------------------------------------------
// Sliding window segment receiver
// Selective-repeat receiver with slot storage and a byte delivery ring.
// ----------------------------------------------------------------------------
// Items enter on the input channel (valid, stall) and results leave on the
// output channel (out_valid, out_stall) through one output register.
// A data byte that does not end a segment gives no result.
// A timeout or an old segment gives its ack on the cycle after the item.
// An ack after a segment in the window follows the slot length read, the
// drain check and the copy of each drained slot, then waits for a free output.
// A read steps through the read and read output states per byte, up to 64
// bytes and at most the ring fill; an empty read answers on the next cycle.
// The slot valid bits are flip-flops; slot lengths, payload and ring are
// RAMs with a registered read, walked by a single sequencer. Reset clears
// the pointers, the fill count, the slot valid bits and the next expected
// sequence number; the RAMs are not cleared. The input stalls while the
// sequencer is busy or the output is stalled. The window length must be
// written through cfg_we and cfg_data only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module sliding_window_segment_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	input  logic        valid,
	output logic        stall,
	input  logic [1:0]  op,
	input  logic [15:0] seq_num,
	input  logic [10:0] seg_len,
	input  logic [7:0]  payload_byte,
	input  logic        last_byte,
	input  logic [7:0]  proto_id,
	input  logic [7:0]  conn_id,
	input  logic [6:0]  read_len,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] ack_num,
	output logic [7:0]  adv_window,
	output logic [7:0]  proto_out,
	output logic [7:0]  conn_out,
	output logic [7:0]  read_byte,
	output logic        read_last
);
	import swsr_pkg::*;

	state_t state_q, state_d;

	logic [7:0]         win_q;
	logic [15:0]        next_q;
	logic [WINDOW_SLOTS-1:0] sval_q;
	logic [RING_AW-1:0] rptr_q, wptr_q;
	logic [FILL_W-1:0]  fill_q;
	logic [LEN_W-1:0]   boff_q;
	logic [7:0]         proto_q, conn_q;
	logic [LEN_W-1:0]   cnt_q, len_q;
	logic [6:0]         rn_q, ri_q;
	logic               pend_q;

	logic        ov_q;
	logic [1:0]  kind_q;
	logic [15:0] ack_q;
	logic [7:0]  adv_q, po_q, co_q, rb_q;
	logic        rl_q;

	logic accept, out_free, out_load;
	assign out_free = !ov_q || !out_stall;
	assign stall    = (state_q != ST_IDLE) || !out_free;
	assign accept   = valid && !stall;

	logic [SLOT_W-1:0] in_slot, nx_slot;
	logic [LEN_W-1:0]  lim;
	logic              inwin, oldseg, keep_byte;
	logic [16:0]       win_end;
	assign in_slot = seq_num[SLOT_W-1:0];
	assign nx_slot = next_q[SLOT_W-1:0];
	assign lim     = (seg_len < LEN_W'(MAX_PAYLOAD)) ? seg_len[LEN_W-1:0] : LEN_W'(MAX_PAYLOAD);
	assign win_end = {1'b0, next_q} + {9'd0, win_q};
	assign inwin   = (seq_num >= next_q) && ({1'b0, seq_num} < win_end);
	assign oldseg  = seq_num < next_q;
	assign keep_byte = boff_q < lim;

	logic [FILL_W-1:0] free_b;
	logic [7:0]        adv;
	assign free_b = FILL_W'(RING_BYTES) - fill_q;
	assign adv    = (free_b <= ADV_LIMIT) ? 8'(free_b >> 10) : 8'd128;

	// Slot length RAM, read at the next expected slot.
	logic             slen_we;
	logic [LEN_W-1:0] slen_wd, slen_rd;
	assign slen_we = accept && (op == OP_DATA) && last_byte && inwin && !sval_q[in_slot];
	assign slen_wd = keep_byte ? boff_q + 1'b1 : boff_q;

	swsr_ram #(.WIDTH(LEN_W), .DEPTH(WINDOW_SLOTS)) u_slen (
		.clk(clk), .we(slen_we), .waddr(in_slot), .wdata(slen_wd),
		.raddr(nx_slot), .rdata(slen_rd)
	);

	// Payload RAM
	logic              pay_we;
	logic [PAY_AW-1:0] pay_wa, pay_ra;
	logic [7:0]        pay_rd;
	assign pay_we = accept && (op == OP_DATA) && keep_byte && inwin && !sval_q[in_slot];
	assign pay_wa = {in_slot, boff_q[OFF_W-1:0]};
	assign pay_ra = {nx_slot, cnt_q[OFF_W-1:0]};

	swsr_ram #(.WIDTH(8), .DEPTH(WINDOW_SLOTS * MAX_PAYLOAD)) u_pay (
		.clk(clk), .we(pay_we), .waddr(pay_wa), .wdata(payload_byte),
		.raddr(pay_ra), .rdata(pay_rd)
	);

	// Ring RAM; each copy write lands in the cycle after its payload read.
	logic               ring_we;
	logic [7:0]         ring_rd;
	assign ring_we = pend_q;

	swsr_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring (
		.clk(clk), .we(ring_we), .waddr(wptr_q), .wdata(pay_rd),
		.raddr(rptr_q), .rdata(ring_rd)
	);

	function automatic logic [RING_AW-1:0] rnext(input logic [RING_AW-1:0] p);
		return ({1'b0, p} + 1'b1 >= (RING_AW+1)'(RING_BYTES)) ? '0 : p + 1'b1;
	endfunction

	logic [6:0] rn_in;
	assign rn_in = (read_len < READ_CAP) ? read_len : READ_CAP;

	assign out_load = (state_q == ST_IDLE && accept && ((op == OP_TIMEOUT) ||
			(op == OP_DATA && last_byte && oldseg) ||
			(op == OP_READ && (rn_in == '0 || fill_q == '0)))) ||
		(state_q == ST_ACK && out_free && !pend_q) ||
		(state_q == ST_READ_OUT && out_free);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_DATA:
							if (last_byte && !oldseg && inwin) state_d = ST_SLOT_RD;
						OP_READ: state_d = ST_READ;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SLOT_RD:
				state_d = ST_DRAIN_CHECK;
			ST_DRAIN_CHECK:
				if (sval_q[nx_slot] && FILL_W'(slen_rd) <= free_b) state_d = ST_COPY;
				else state_d = ST_ACK;
			ST_COPY:
				if (cnt_q == len_q) state_d = ST_SLOT_RD;
			ST_ACK:
				if (out_free && !pend_q) state_d = ST_IDLE;
			ST_READ:
				if (rn_q == '0) state_d = ST_IDLE;
				else state_d = ST_READ_OUT;
			ST_READ_OUT:
				if (out_free && ri_q + 7'd1 == rn_q) state_d = ST_IDLE;
				else if (out_free) state_d = ST_READ;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			win_q   <= 8'd128;
			next_q  <= '0;
			sval_q  <= '0;
			rptr_q  <= '0;
			wptr_q  <= '0;
			fill_q  <= '0;
			boff_q  <= '0;
			pend_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) win_q <= cfg_data;
			ov_q   <= out_load || (ov_q && out_stall);
			pend_q <= (state_q == ST_COPY) && (cnt_q != len_q);
			if (pend_q) wptr_q <= rnext(wptr_q);
			unique case (state_q)
				ST_IDLE: if (accept) begin
					unique case (op)
						OP_DATA: begin
							if (!last_byte) begin
								if (keep_byte) boff_q <= boff_q + 1'b1;
							end else begin
								boff_q <= '0;
								if (oldseg) begin
									kind_q <= KIND_ACK; ack_q <= next_q;
									adv_q <= adv; po_q <= proto_id; co_q <= conn_id;
									rb_q <= '0; rl_q <= 1'b1;
								end else if (inwin && !sval_q[in_slot]) begin
									sval_q[in_slot] <= 1'b1;
								end
							end
						end
						OP_TIMEOUT: begin
							kind_q <= KIND_ACK; ack_q <= next_q;
							adv_q <= adv; po_q <= TIMEOUT_PROTO; co_q <= conn_id;
							rb_q <= '0; rl_q <= 1'b1;
						end
						OP_READ: begin
							ri_q <= '0;
							rn_q <= (FILL_W'(rn_in) > fill_q) ? 7'(fill_q) : rn_in;
							if (rn_in == 0 || fill_q == 0) begin
								kind_q <= KIND_EMPTY; ack_q <= '0;
								adv_q <= '0; po_q <= '0; co_q <= '0;
								rb_q <= '0; rl_q <= 1'b1;
							end
						end
						default: ;
					endcase
					proto_q <= proto_id;
					conn_q  <= conn_id;
				end
				ST_DRAIN_CHECK: begin
					cnt_q <= '0;
					len_q <= slen_rd;
				end
				ST_COPY: begin
					if (cnt_q == len_q) begin
						fill_q <= fill_q + FILL_W'(len_q);
						sval_q[nx_slot] <= 1'b0;
						next_q <= next_q + 16'd1;
					end else begin
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				ST_ACK: if (out_free && !pend_q) begin
					kind_q <= KIND_ACK; ack_q <= next_q;
					adv_q <= adv; po_q <= proto_q; co_q <= conn_q;
					rb_q <= '0; rl_q <= 1'b1;
				end
				ST_READ_OUT: if (out_free) begin
					kind_q <= KIND_BYTE; ack_q <= '0;
					adv_q <= '0; po_q <= '0; co_q <= '0;
					rb_q <= ring_rd; rl_q <= (ri_q + 7'd1 == rn_q);
					ri_q <= ri_q + 7'd1;
					rptr_q <= rnext(rptr_q);
					fill_q <= fill_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign kind       = kind_q;
	assign ack_num    = ack_q;
	assign adv_window = adv_q;
	assign proto_out  = po_q;
	assign conn_out   = co_q;
	assign read_byte  = rb_q;
	assign read_last  = rl_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_BYTES))
		else $error("ring fill exceeds capacity");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_stall |=> ov_q && $stable(rb_q) && $stable(kind_q))
		else $error("stalled result changed");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> stall)
		else $error("input taken while busy");
	a_copy_write: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $past(state_q) == ST_COPY)
		else $error("ring write outside drain");

endmodule

>>> test/sliding_window_segment_receiver_tb.sv
// ----------------------------------------------------------------------------
// Sliding window segment receiver testbench
// Sends data segments, timeouts, reads and ignored items with random gaps and
// output stalls, predicts every ack and read result from a model of the
// slots and ring, and compares each result field by field.
// ----------------------------------------------------------------------------
module sliding_window_segment_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swsr_pkg::*;

	typedef struct packed {
		op_t         op;
		logic [15:0] seq;
		logic [10:0] len;
		logic [7:0]  pbyte;
		logic        last;
		logic [7:0]  proto;
		logic [7:0]  conn;
		logic [6:0]  rlen;
	} seg_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] ack;
		logic [7:0]  adv;
		logic [7:0]  proto;
		logic [7:0]  conn;
		logic [7:0]  rbyte;
		logic        rlast;
	} rx_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [7:0] cfg_data = 8'd128;
	logic valid = 0;
	logic stall;
	logic out_valid;
	logic out_stall = 1;
	logic [1:0] kind;
	logic [15:0] ack_num;
	logic [7:0] adv_window, proto_out, conn_out, read_byte;
	logic read_last;
	seg_item_t cur = '0;

	seg_item_t pending_items[$];
	rx_result_t expected_results[$];
	int gap = 0;
	int accepted = 0;
	int failures = 0;
	int cycles = 0;
	int hold_left = 0;
	bit hold_done = 0;

	int win_len = 128;
	int next_seq = 0;
	bit slot_full[WINDOW_SLOTS];
	int slot_size[WINDOW_SLOTS];
	logic [7:0] slot_mem[WINDOW_SLOTS*MAX_PAYLOAD];
	logic [7:0] ring_mem[RING_BYTES];
	int rd_ptr = 0, wr_ptr = 0, fill = 0, offset = 0;
	int seg_base = 0;

	always #2 clk = ~clk;

	sliding_window_segment_receiver DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.valid(valid), .stall(stall), .op(cur.op), .seq_num(cur.seq),
		.seg_len(cur.len), .payload_byte(cur.pbyte), .last_byte(cur.last),
		.proto_id(cur.proto), .conn_id(cur.conn), .read_len(cur.rlen),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.ack_num(ack_num), .adv_window(adv_window), .proto_out(proto_out),
		.conn_out(conn_out), .read_byte(read_byte), .read_last(read_last)
	);

	function automatic int advertised();
		int free_space;
		free_space = RING_BYTES - fill;
		return (free_space <= 131072) ? free_space / 1024 : 128;
	endfunction

	function automatic void push_ack(logic [7:0] proto, logic [7:0] conn);
		rx_result_t r;
		r = '{KIND_ACK, 16'(next_seq), 8'(advertised()), proto, conn, 8'd0, 1'b1};
		expected_results.push_back(r);
	endfunction

	function automatic void predict_receiver(seg_item_t it);
		int n, slot, lim, cnt;
		bit inwin;
		rx_result_t r;
		case (it.op)
			OP_TIMEOUT: push_ack(TIMEOUT_PROTO, it.conn);
			OP_READ: begin
				n = (it.rlen < 64) ? it.rlen : 64;
				if (n > fill)
					n = fill;
				if (n == 0) begin
					r = '{KIND_EMPTY, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1};
					expected_results.push_back(r);
				end
				for (int i = 0; i < n; i++) begin
					r = '{KIND_BYTE, 16'd0, 8'd0, 8'd0, 8'd0, ring_mem[rd_ptr], i == n - 1};
					expected_results.push_back(r);
					rd_ptr = (rd_ptr + 1) % RING_BYTES;
				end
				fill -= n;
			end
			OP_DATA: begin
				slot = it.seq % WINDOW_SLOTS;
				lim = (it.len < MAX_PAYLOAD) ? it.len : MAX_PAYLOAD;
				inwin = (it.seq >= next_seq) && (int'(it.seq) < next_seq + win_len);
				if (offset < lim) begin
					if (inwin && !slot_full[slot])
						slot_mem[slot*MAX_PAYLOAD + offset] = it.pbyte;
					offset++;
				end
				if (it.last) begin
					cnt = offset;
					offset = 0;
					if (it.seq < next_seq)
						push_ack(it.proto, it.conn);
					else if (inwin) begin
						if (!slot_full[slot]) begin
							slot_full[slot] = 1;
							slot_size[slot] = cnt;
						end
						for (int k = 0; k < WINDOW_SLOTS; k++) begin
							slot = next_seq % WINDOW_SLOTS;
							if (!slot_full[slot] || slot_size[slot] > RING_BYTES - fill)
								break;
							for (int i = 0; i < slot_size[slot]; i++) begin
								ring_mem[wr_ptr] = slot_mem[slot*MAX_PAYLOAD + i];
								wr_ptr = (wr_ptr + 1) % RING_BYTES;
							end
							fill += slot_size[slot];
							slot_full[slot] = 0;
							slot_size[slot] = 0;
							next_seq = (next_seq + 1) & 16'hFFFF;
						end
						push_ack(it.proto, it.conn);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if ((accepted / 40) % 3 == 0)
			return 0;
		return (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 30);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 0;
			gap <= 0;
		end else begin
			if (valid && !stall) begin
				predict_receiver(cur);
				accepted <= accepted + 1;
			end
			if (!valid || !stall) begin
				if (gap > 0) begin
					gap <= gap - 1;
					valid <= 0;
				end else if (pending_items.size() > 0) begin
					cur <= pending_items.pop_front();
					valid <= 1;
					gap <= random_gap();
				end else
					valid <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		rx_result_t e;
		int r;
		if (!arst_n) begin
			out_stall <= 1;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result kind %0d", kind);
					failures++;
				end else begin
					e = expected_results.pop_front();
					if (kind != e.kind) begin
						$error("kind expected %0d actual %0d", e.kind, kind); failures++;
					end
					if (ack_num != e.ack) begin
						$error("ack_num expected %0d actual %0d", e.ack, ack_num); failures++;
					end
					if (adv_window != e.adv) begin
						$error("adv_window expected %0d actual %0d", e.adv, adv_window);
						failures++;
					end
					if (proto_out != e.proto) begin
						$error("proto_out expected %0d actual %0d", e.proto, proto_out);
						failures++;
					end
					if (conn_out != e.conn) begin
						$error("conn_out expected %0d actual %0d", e.conn, conn_out); failures++;
					end
					if (read_byte != e.rbyte) begin
						$error("read_byte expected %0d actual %0d", e.rbyte, read_byte);
						failures++;
					end
					if (read_last != e.rlast) begin
						$error("read_last expected %0d actual %0d", e.rlast, read_last);
						failures++;
					end
				end
			end
			r = $urandom_range(0, 99);
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1;
			end else if (!hold_done && accepted > 150) begin
				hold_done <= 1;
				hold_left <= 600;
				out_stall <= 1;
			end else if ((cycles / 300) % 3 == 1)
				out_stall <= 0;
			else
				out_stall <= (r < 20) || (r < 23 && out_stall);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("sliding_window_segment_receiver test failed");
			$finish;
		end
	end

	task automatic add_item(op_t op, int s, int len, bit last, int rlen);
		seg_item_t it;
		it.op = op;
		it.seq = 16'(s);
		it.len = 11'(len);
		it.pbyte = 8'($urandom);
		it.last = last;
		it.proto = 8'($urandom);
		it.conn = 8'($urandom);
		it.rlen = 7'(rlen);
		pending_items.push_back(it);
	endtask

	task automatic add_noise();
		add_item(op_t'($urandom_range(1, 3)), $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic add_segment(int s, int len, int n, bit mix);
		for (int i = 0; i < n; i++) begin
			if (mix && $urandom_range(0, 9) == 0)
				add_noise();
			add_item(OP_DATA, s, len, i == n - 1, $urandom);
		end
	endtask

	task automatic set_window(int v);
		wait (pending_items.size() == 0 && !valid && expected_results.size() == 0);
		repeat (40) @(posedge clk);
		cfg_we <= 1;
		cfg_data <= 8'(v);
		@(posedge clk);
		cfg_we <= 0;
		win_len = v;
	endtask

	task automatic random_phase(int items);
		int k, len, n, r;
		int order[$];
		int stop_at;
		stop_at = pending_items.size() + items;
		while (pending_items.size() < stop_at) begin
			k = $urandom_range(1, (win_len < 6) ? win_len : 6);
			order.delete();
			for (int i = 0; i < k; i++)
				order.insert($urandom_range(0, order.size()), seg_base + i);
			foreach (order[i]) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 6);
				r = $urandom_range(0, 9);
				n = (r == 0) ? $urandom_range(1, 8) : (len == 0 ? 1 : (len > 8 ? 8 : len));
				add_segment(order[i], len, n, 1);
				if ($urandom_range(0, 4) == 0)
					add_segment(order[i], len, n, 0);
				r = $urandom_range(0, 9);
				if (r < 2)
					add_item(OP_READ, $urandom, $urandom, $urandom, $urandom);
				else if (r == 2 && seg_base > 0)
					add_segment($urandom_range(0, seg_base - 1), 2, 2, 0);
				else if (r == 3)
					add_segment($urandom, $urandom_range(0, 3), 1, 0);
			end
			seg_base += k;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		set_window(128);

		add_item(OP_TIMEOUT, 16'hFFFF, 11'h7FF, 1, 127);
		add_item(OP_READ, 0, 0, 0, 0);
		add_segment(0, 0, 1, 0);
		add_segment(1, 3, 3, 0);
		add_item(OP_READ, 0, 0, 0, 127);
		add_segment(2, 2, 4, 0);
		add_segment(3, 1024, 2, 0);
		add_item(OP_DATA, 4, 3, 0, 0);
		add_item(OP_OTHER, 0, 0, 0, 0);
		add_item(OP_TIMEOUT, 0, 0, 0, 0);
		add_item(OP_DATA, 9, 3, 0, 0);
		add_item(OP_DATA, 5, 3, 1, 0);
		add_item(OP_DATA, 4, 2, 1, 0);
		add_segment(5, 2, 2, 0);
		add_segment(0, 1, 1, 0);
		add_segment(65535, 1, 1, 0);
		add_item(OP_READ, 0, 0, 0, 64);
		add_item(OP_READ, 0, 0, 0, 64);
		seg_base = 6;

		random_phase(150);
		set_window(1);
		random_phase(40);
		set_window(37);
		random_phase(50);
		set_window(128);
		random_phase(20);
		add_item(OP_READ, 0, 0, 0, 64);

		wait (pending_items.size() == 0 && !valid && expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (failures == 0 && expected_results.size() == 0)
			$display("sliding_window_segment_receiver test passed");
		else
			$display("sliding_window_segment_receiver test failed");
		$finish;
	end
endmodule
